### rtl/core/dda_pkg.sv
// Package: shared types, microcode table and constants for the DDA line rasterizer.
package dda_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 32;
  localparam int PC_W    = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [PC_W-1:0]    pc_t;

  // Microprogram step addresses
  localparam pc_t STEP_WAIT = 2'd0;
  localparam pc_t STEP_SPAN = 2'd1;
  localparam pc_t STEP_INIT = 2'd2;
  localparam pc_t STEP_EMIT = 2'd3;

  // Jump conditions; when the condition is false the step counter holds
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_LINE_DONE
  } cond_t;

  // Datapath controls carried by one control word
  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic calc_span;
    logic init_acc;
    logic out_valid;
    logic step_acc;
  } ctl_t;

  // Status returned to the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic is_last;
  } stat_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_t cond;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.ctl.in_ready  = 1'b1;
        w.ctl.load_in   = 1'b1;
        w.cond          = COND_IN_FIRE;
        w.target        = STEP_SPAN;
      end
      STEP_SPAN: begin
        w.ctl.calc_span = 1'b1;
        w.cond          = COND_ALWAYS;
        w.target        = STEP_INIT;
      end
      STEP_INIT: begin
        w.ctl.init_acc  = 1'b1;
        w.cond          = COND_ALWAYS;
        w.target        = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.ctl.out_valid = 1'b1;
        w.ctl.step_acc  = 1'b1;
        w.cond          = COND_LINE_DONE;
        w.target        = STEP_WAIT;
      end
      default: begin
        w.cond          = COND_ALWAYS;
        w.target        = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/dda_req_if.sv
// Interface: line request channel (start, end, color).
interface dda_req_if;
  logic            valid;
  logic            ready;
  dda_pkg::coord_t x_start;
  dda_pkg::coord_t y_start;
  dda_pkg::coord_t x_end;
  dda_pkg::coord_t y_end;
  dda_pkg::color_t color;

  modport source (output valid, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, color, output ready);
endinterface

### rtl/core/dda_pix_if.sv
// Interface: pixel output channel.
interface dda_pix_if;
  logic            valid;
  logic            ready;
  dda_pkg::coord_t pixel_x;
  dda_pkg::coord_t pixel_y;
  dda_pkg::color_t pixel_color;
  logic            last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

### rtl/core/dda_seq.sv
// Module: microcode sequencer, step counter plus control ROM with conditional jumps.
module dda_seq (
  input  logic          clk,
  input  logic          rst,
  input  dda_pkg::stat_t stat,
  output dda_pkg::ctl_t  ctl
);

  dda_pkg::pc_t    pc;
  dda_pkg::pc_t    pc_next;
  dda_pkg::uword_t word;
  logic            taken;

  always_comb begin
    word = dda_pkg::ucode(pc);
    case (word.cond)
      dda_pkg::COND_ALWAYS:    taken = 1'b1;
      dda_pkg::COND_IN_FIRE:   taken = stat.in_fire;
      dda_pkg::COND_LINE_DONE: taken = stat.out_fire && stat.is_last;
      default:                 taken = 1'b1;
    endcase
    // hold the step until its condition is met
    pc_next = taken ? word.target : pc;
    ctl     = word.ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dda_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/core/dda_datapath.sv
// Module: DDA datapath, coordinate clamp, span, and remainder accumulators.
module dda_datapath #(
  parameter int MAX_COORD = 63
) (
  input  logic            clk,
  input  dda_pkg::ctl_t   ctl,
  input  logic            in_fire,
  input  logic            out_fire,
  input  dda_pkg::coord_t x_start,
  input  dda_pkg::coord_t y_start,
  input  dda_pkg::coord_t x_end,
  input  dda_pkg::coord_t y_end,
  input  dda_pkg::color_t color,
  output dda_pkg::coord_t pixel_x,
  output dda_pkg::coord_t pixel_y,
  output dda_pkg::color_t pixel_color,
  output logic            is_last
);

  localparam dda_pkg::coord_t CMAX = dda_pkg::coord_t'(MAX_COORD);

  dda_pkg::coord_t xs, ys, xe, ye;
  dda_pkg::color_t col;
  dda_pkg::coord_t adx, ady, steps, px, py, rx, ry, k;
  logic            x_neg, y_neg;

  dda_pkg::coord_t     s_max;
  logic [dda_pkg::COORD_W:0] sum_x, sum_y;
  logic                x_carry, y_carry;

  function automatic dda_pkg::coord_t clamp(input dda_pkg::coord_t v);
    return (v > CMAX) ? CMAX : v;
  endfunction

  always_comb begin
    s_max   = (adx > ady) ? adx : ady;
    sum_x   = {1'b0, rx} + {1'b0, adx};
    sum_y   = {1'b0, ry} + {1'b0, ady};
    x_carry = sum_x >= {1'b0, steps};
    y_carry = sum_y >= {1'b0, steps};
    is_last = (k == steps);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in && in_fire) begin
      xs  <= clamp(x_start);
      ys  <= clamp(y_start);
      xe  <= clamp(x_end);
      ye  <= clamp(y_end);
      col <= color;
    end
    if (ctl.calc_span) begin
      x_neg <= xe < xs;
      y_neg <= ye < ys;
      adx   <= (xe < xs) ? xs - xe : xe - xs;
      ady   <= (ye < ys) ? ys - ye : ye - ys;
    end
    if (ctl.init_acc) begin
      // a negative span rounds toward minus infinity: bias the remainder by steps-1
      steps <= s_max;
      px    <= xs;
      py    <= ys;
      rx    <= x_neg ? s_max - 1'b1 : '0;
      ry    <= y_neg ? s_max - 1'b1 : '0;
      k     <= '0;
    end
    if (ctl.step_acc && out_fire && !is_last) begin
      k <= k + 1'b1;
      if (x_carry) begin
        rx <= dda_pkg::coord_t'(sum_x - {1'b0, steps});
        px <= x_neg ? px - 1'b1 : px + 1'b1;
      end else begin
        rx <= sum_x[dda_pkg::COORD_W-1:0];
      end
      if (y_carry) begin
        ry <= dda_pkg::coord_t'(sum_y - {1'b0, steps});
        py <= y_neg ? py - 1'b1 : py + 1'b1;
      end else begin
        ry <= sum_y[dda_pkg::COORD_W-1:0];
      end
    end
  end

  assign pixel_x     = px;
  assign pixel_y     = py;
  assign pixel_color = col;

endmodule

### rtl/core/dda_line_rasterizer.sv
// Top level: DDA line rasterizer, microcoded sequencer driving the span datapath.
// Takes one line request (start point, end point, color) on req and emits its
// pixels on pix in order, one transaction per pixel, with last set on the final
// pixel. The step count S is the larger of the absolute x and y spans and S+1
// pixels result (one pixel for a zero-length line); coordinates above MAX_COORD
// are saturated to MAX_COORD first. Positions are tracked exactly with
// remainder accumulators, so pixel k is start + floor(k*span/S). One line is
// handled at a time: a request passes through the setup steps capture, span
// and init, and then S+1 pixels follow at one pixel per cycle while pix.ready
// stays high. The emit step of the microprogram, which advances both
// accumulators once per accepted pixel, sets that rate.
module dda_line_rasterizer #(
  parameter int MAX_COORD = 63
) (
  input  logic      clk,
  input  logic      rst,
  dda_req_if.sink   req,
  dda_pix_if.source pix
);

  dda_pkg::ctl_t  ctl;
  dda_pkg::stat_t stat;
  logic           is_last;

  // handshake qualifiers come straight from the current control word
  assign req.ready     = ctl.in_ready;
  assign pix.valid     = ctl.out_valid;
  assign pix.last      = is_last;
  assign stat.in_fire  = req.valid && ctl.in_ready;
  assign stat.out_fire = ctl.out_valid && pix.ready;
  assign stat.is_last  = is_last;

  dda_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  dda_datapath #(
    .MAX_COORD (MAX_COORD)
  ) u_dp (
    .clk         (clk),
    .ctl         (ctl),
    .in_fire     (stat.in_fire),
    .out_fire    (stat.out_fire),
    .x_start     (req.x_start),
    .y_start     (req.y_start),
    .x_end       (req.x_end),
    .y_end       (req.y_end),
    .color       (req.color),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .pixel_color (pix.pixel_color),
    .is_last     (is_last)
  );

  // one line at a time: never accept a request while a pixel is offered
  a_one_line: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && pix.valid))
    else $error("request accepted while pixels pending");

  // an accepted request blocks further requests next cycle
  a_req_block: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request channel reopened too early");

  // the final pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && pix.last) |=> (!pix.valid && req.ready))
    else $error("pixels continue past last");

  // a non-final pixel is followed by another pixel
  a_continue: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && !pix.last) |=> pix.valid)
    else $error("line ended without last");

endmodule
